// ----- hw/rtl/led_pkg.sv -----
// Shared definitions for the line edit buffer: command and register codes,
// port widths, cell operations and the word-character test.
// No dependencies.
package led_pkg;

  // Default line capacity (number of cells in the ring)
  localparam int unsigned BUFFER_SIZE_DEF = 256;

  localparam int unsigned CMD_W     = 5;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 40;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CJK     = 1'd1;

  // Edit commands
  localparam logic [CMD_W-1:0] CMD_INSERT    = 5'd0;
  localparam logic [CMD_W-1:0] CMD_CJK_INS   = 5'd1;
  localparam logic [CMD_W-1:0] CMD_WORD_LEFT = 5'd2;
  localparam logic [CMD_W-1:0] CMD_WORD_RGHT = 5'd3;
  localparam logic [CMD_W-1:0] CMD_ERASE     = 5'd4;
  localparam logic [CMD_W-1:0] CMD_HOME      = 5'd5;
  localparam logic [CMD_W-1:0] CMD_END       = 5'd6;
  localparam logic [CMD_W-1:0] CMD_DEL_NWORD = 5'd7;
  localparam logic [CMD_W-1:0] CMD_DEL_PWORD = 5'd8;
  localparam logic [CMD_W-1:0] CMD_DEL_NEXT  = 5'd9;
  localparam logic [CMD_W-1:0] CMD_DEL_PREV  = 5'd10;
  localparam logic [CMD_W-1:0] CMD_DEL_CUR   = 5'd11;
  localparam logic [CMD_W-1:0] CMD_RIGHT     = 5'd12;
  localparam logic [CMD_W-1:0] CMD_LEFT      = 5'd13;
  localparam logic [CMD_W-1:0] CMD_UPPER     = 5'd14;
  localparam logic [CMD_W-1:0] CMD_LOWER     = 5'd15;

  // Per-cycle operation broadcast to every cell of the ring
  typedef enum logic [2:0] {
    OP_HOLD,     // keep byte
    OP_ROT_L,    // take right neighbor (cursor moves right)
    OP_ROT_R,    // take left neighbor (cursor moves left)
    OP_INS,      // cells at or above threshold take right neighbor
    OP_DEL_CUR,  // cells below threshold take right neighbor
    OP_DEL_PRV,  // cells above threshold take left neighbor
    OP_UPPER,    // ASCII upper case
    OP_LOWER     // ASCII lower case
  } cell_op_e;

  // ASCII letters and digits make up a word
  function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
    is_word_char = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
                   (c >= 8'h61 && c <= 8'h7a);
  endfunction

endpackage

// ----- hw/rtl/led_cell.sv -----
// One byte cell of the line ring: holds a character and takes its neighbor's
// byte, keeps it, or changes its case as the broadcast operation says.
// Depends on led_pkg.
module led_cell #(
  parameter int unsigned BUFFER_SIZE = led_pkg::BUFFER_SIZE_DEF,
  parameter int unsigned IDX         = 0
) (
  input  logic                                clk_i,
  input  led_pkg::cell_op_e                   op_i,
  input  logic [$clog2(BUFFER_SIZE+1)-1:0]    thr_i,
  input  logic [led_pkg::CHAR_W-1:0]          prv_i,
  input  logic [led_pkg::CHAR_W-1:0]          nxt_i,
  output logic [led_pkg::CHAR_W-1:0]          data_o
);
  import led_pkg::*;

  localparam int unsigned CW = $clog2(BUFFER_SIZE + 1);
  localparam logic [CW-1:0] K = CW'(IDX);

  logic [CHAR_W-1:0] data_q, data_d;

  // Select the next byte of this cell
  always_comb begin
    data_d = data_q;
    case (op_i)
      OP_HOLD:    data_d = data_q;
      OP_ROT_L:   data_d = nxt_i;
      OP_ROT_R:   data_d = prv_i;
      OP_INS:     if (K >= thr_i) data_d = nxt_i;
      OP_DEL_CUR: if (K < thr_i) data_d = nxt_i;
      OP_DEL_PRV: if (K > thr_i) data_d = prv_i;
      OP_UPPER:   if (data_q >= 8'h61 && data_q <= 8'h7a) data_d = data_q - 8'd32;
      OP_LOWER:   if (data_q >= 8'h41 && data_q <= 8'h5a) data_d = data_q + 8'd32;
      default:    data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- hw/rtl/led_ctrl.sv -----
// Command sequencer of the line edit buffer: handshakes, configuration
// registers, cursor and length, and the operation driven onto the cell ring.
// Depends on led_pkg.
module led_ctrl #(
  parameter int unsigned BUFFER_SIZE = led_pkg::BUFFER_SIZE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [led_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [led_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                s_valid_i,
  output logic                                s_ready_o,
  input  logic [led_pkg::CMD_W-1:0]           cmd_i,
  input  logic [led_pkg::CHAR_W-1:0]          char_i,
  input  logic                                rep_i,
  output logic                                m_valid_o,
  input  logic                                m_ready_i,
  output logic [led_pkg::M_TDATA_W-1:0]       m_data_o,
  input  logic [led_pkg::CHAR_W-1:0]          first_i,
  input  logic [led_pkg::CHAR_W-1:0]          last_i,
  output led_pkg::cell_op_e                   op_o,
  output logic [$clog2(BUFFER_SIZE+1)-1:0]    thr_o,
  output logic [led_pkg::CHAR_W-1:0]          ring_o
);
  import led_pkg::*;

  localparam int unsigned CW    = $clog2(BUFFER_SIZE + 1);
  localparam int unsigned MW    = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned M_PAD = M_TDATA_W - (3 * CHAR_W + CHAR_W + 2);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_INS, ACT_WLEFT, ACT_WRIGHT, ACT_ERASE, ACT_HOME, ACT_END,
    ACT_DNWORD, ACT_DPWORD, ACT_DCUR, ACT_DPRV, ACT_RIGHT, ACT_LEFT,
    ACT_UPPER, ACT_LOWER
  } act_e;

  logic [1:0]          state_q, state_d;
  act_e                act_q, act_d, act_dec;
  logic                phase_q, phase_d;
  logic [CW-1:0]       cur_q, cur_d, len_q, len_d;
  logic [CFG_W-1:0]    max_len_q, max_len_d;
  logic                cjk_q, cjk_d;
  logic                m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;
  logic [CHAR_W-1:0]   ch_q, ch_d;
  logic                rep_q, rep_d, pass_q, pass_d, full_q, full_d, pass_dec;

  logic [MW-1:0]       ml_ext;
  logic [CW-1:0]       cap;
  logic                at_end, at_home, fwd_hit, back_hit;
  logic [CHAR_W-1:0]   cac;

  // Capacity is the smaller of max_length and the ring size
  assign ml_ext  = MW'(max_len_q);
  assign cap     = (ml_ext > MW'(BUFFER_SIZE)) ? CW'(BUFFER_SIZE) : CW'(ml_ext);
  assign at_end  = (cur_q == len_q);
  assign at_home = (cur_q == '0);
  // Forward scans cross word bytes in phase 0, then separators in phase 1;
  // backward scans cross separators in phase 0, then word bytes in phase 1
  assign fwd_hit  = !at_end  && (is_word_char(first_i) ^ phase_q);
  assign back_hit = !at_home && (!is_word_char(last_i) ^ phase_q);
  assign cac      = (cur_q < len_q) ? first_i : '0;
  assign thr_o    = len_q - cur_q;

  // Decode the incoming command
  always_comb begin
    act_dec  = ACT_NONE;
    pass_dec = 1'b0;
    if (max_len_q != '0) begin
      unique case (cmd_i) inside
        CMD_INSERT:               act_dec = ACT_INS;
        CMD_CJK_INS: begin
          if (cjk_q) act_dec = ACT_INS;
          else       pass_dec = 1'b1;
        end
        CMD_WORD_LEFT:            act_dec = ACT_WLEFT;
        CMD_WORD_RGHT:            act_dec = ACT_WRIGHT;
        CMD_ERASE:                act_dec = ACT_ERASE;
        CMD_HOME:                 act_dec = ACT_HOME;
        CMD_END:                  act_dec = ACT_END;
        CMD_DEL_NWORD:            act_dec = ACT_DNWORD;
        CMD_DEL_PWORD:            act_dec = ACT_DPWORD;
        CMD_DEL_NEXT, CMD_DEL_CUR: act_dec = ACT_DCUR;
        CMD_DEL_PREV:             act_dec = ACT_DPRV;
        CMD_RIGHT:                act_dec = ACT_RIGHT;
        CMD_LEFT:                 act_dec = ACT_LEFT;
        CMD_UPPER:                act_dec = ACT_UPPER;
        CMD_LOWER:                act_dec = ACT_LOWER;
        default:                  pass_dec = 1'b1;
      endcase
    end
  end

  // Sequence one command over the ring
  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    phase_d   = phase_q;
    cur_d     = cur_q;
    len_d     = len_q;
    max_len_d = max_len_q;
    cjk_d     = cjk_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    ch_d      = ch_q;
    rep_d     = rep_q;
    pass_d    = pass_q;
    full_d    = full_q;
    op_o      = OP_HOLD;
    s_ready_o = (state_q == ST_IDLE);

    // Register writes
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_LEN: max_len_d = cfg_wdata_i;
        CFG_CJK:     cjk_d     = cfg_wdata_i[0];
        default:     max_len_d = max_len_q;
      endcase
    end

    // Drop the result once taken
    if (m_valid_q && m_ready_i) m_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          act_d   = act_dec;
          pass_d  = pass_dec;
          full_d  = 1'b0;
          ch_d    = char_i;
          rep_d   = rep_i;
          phase_d = 1'b0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        state_d = ST_FIN;
        unique case (act_q)
          ACT_NONE: state_d = ST_FIN;
          ACT_INS: begin
            if (len_q < cap) begin
              op_o  = OP_INS;
              cur_d = cur_q + 1'b1;
              len_d = len_q + 1'b1;
            end else begin
              full_d = rep_q;
            end
          end
          ACT_WLEFT: begin
            if (back_hit) begin
              op_o    = OP_ROT_R;
              cur_d   = cur_q - 1'b1;
              state_d = ST_RUN;
            end else if (!phase_q) begin
              phase_d = 1'b1;
              state_d = ST_RUN;
            end
          end
          ACT_WRIGHT: begin
            if (fwd_hit) begin
              op_o    = OP_ROT_L;
              cur_d   = cur_q + 1'b1;
              state_d = ST_RUN;
            end else if (!phase_q) begin
              phase_d = 1'b1;
              state_d = ST_RUN;
            end
          end
          ACT_ERASE: begin
            cur_d = '0;
            len_d = '0;
          end
          ACT_HOME: begin
            if (!at_home) begin
              op_o    = OP_ROT_R;
              cur_d   = cur_q - 1'b1;
              state_d = ST_RUN;
            end
          end
          ACT_END: begin
            if (!at_end) begin
              op_o    = OP_ROT_L;
              cur_d   = cur_q + 1'b1;
              state_d = ST_RUN;
            end
          end
          ACT_DNWORD: begin
            if (fwd_hit) begin
              op_o    = OP_DEL_CUR;
              len_d   = len_q - 1'b1;
              state_d = ST_RUN;
            end else if (!phase_q) begin
              phase_d = 1'b1;
              state_d = ST_RUN;
            end
          end
          ACT_DPWORD: begin
            if (back_hit) begin
              op_o    = OP_DEL_PRV;
              cur_d   = cur_q - 1'b1;
              len_d   = len_q - 1'b1;
              state_d = ST_RUN;
            end else if (!phase_q) begin
              phase_d = 1'b1;
              state_d = ST_RUN;
            end
          end
          ACT_DCUR: begin
            if (!at_end) begin
              op_o  = OP_DEL_CUR;
              len_d = len_q - 1'b1;
            end
          end
          ACT_DPRV: begin
            if (!at_home) begin
              op_o  = OP_DEL_PRV;
              cur_d = cur_q - 1'b1;
              len_d = len_q - 1'b1;
            end
          end
          ACT_RIGHT: begin
            if (!at_end) begin
              op_o  = OP_ROT_L;
              cur_d = cur_q + 1'b1;
            end
          end
          ACT_LEFT: begin
            if (!at_home) begin
              op_o  = OP_ROT_R;
              cur_d = cur_q - 1'b1;
            end
          end
          ACT_UPPER: op_o = OP_UPPER;
          ACT_LOWER: op_o = OP_LOWER;
          default:   state_d = ST_FIN;
        endcase
      end
      ST_FIN: begin
        // Load the result once the output register is free
        if (!m_valid_q || m_ready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {{M_PAD{1'b0}}, cac, CHAR_W'(len_q), CHAR_W'(cur_q), full_q,
                       (pass_q ? ch_q : {CHAR_W{1'b0}}), pass_q};
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Feed the insert byte into the top of the ring, else close the ring
  assign ring_o = (op_o == OP_INS) ? ch_q : first_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      act_q     <= ACT_NONE;
      phase_q   <= 1'b0;
      cur_q     <= '0;
      len_q     <= '0;
      max_len_q <= 8'd255;
      cjk_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      act_q     <= act_d;
      phase_q   <= phase_d;
      cur_q     <= cur_d;
      len_q     <= len_d;
      max_len_q <= max_len_d;
      cjk_q     <= cjk_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    ch_q     <= ch_d;
    rep_q    <= rep_d;
    pass_q   <= pass_d;
    full_q   <= full_d;
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

endmodule

// ----- hw/rtl/line_edit_buffer.sv -----
// Top level of the line edit buffer: command sequencer plus a ring of byte
// cells that holds the line, rotated so the cursor byte sits in cell 0.
// Depends on led_pkg, led_cell and led_ctrl.
//
//  Channel   Direction  Signals                              Content
//  s_axis    in         tvalid/tready/tdata[15:0]/tuser[4:0]  one edit command
//  m_axis    out        tvalid/tready/tdata[39:0]             one result per item
//  cfg       in         cfg_we_i/cfg_idx_i/cfg_wdata_i        max_length, cjk_mode
//
// One-step commands go from acceptance through a run step and a finish step to
// the result. Word moves, word deletes, home and end walk the ring one position
// per cycle; the single-position shift of the cell row sets this pace.
// Reset clears cursor, length and cjk_mode and sets max_length to 255; cell contents stay undefined.
// A result waiting on m_axis does not block acceptance of the next item, which
// then waits in its last step until the output register is free.
module line_edit_buffer #(
  parameter int unsigned BUFFER_SIZE = led_pkg::BUFFER_SIZE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [led_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [led_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // char_in[7:0], report_full[8], zero[15:9]
  input  logic [led_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // cmd[4:0]
  input  logic [led_pkg::CMD_W-1:0]        s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // passed_back[0], char_back[8:1], full_res[9], cursor[17:10],
  // line_length[25:18], char_at_cursor[33:26], zero[39:34]
  output logic [led_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
  import led_pkg::*;

  localparam int unsigned CW = $clog2(BUFFER_SIZE + 1);

  cell_op_e          op;
  logic [CW-1:0]     thr;
  logic [CHAR_W-1:0] ring_byte;
  logic [CHAR_W-1:0] cell_data [BUFFER_SIZE];

  led_ctrl #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .cmd_i       (s_axis_tuser),
    .char_i      (s_axis_tdata[CHAR_W-1:0]),
    .rep_i       (s_axis_tdata[CHAR_W]),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .first_i     (cell_data[0]),
    .last_i      (cell_data[BUFFER_SIZE-1]),
    .op_o        (op),
    .thr_o       (thr),
    .ring_o      (ring_byte)
  );

  // Ring of cells: cell k holds the byte at line index cursor + k
  for (genvar k = 0; k < BUFFER_SIZE; k++) begin : g_cell
    logic [CHAR_W-1:0] prv, nxt;
    assign prv = (k == 0) ? cell_data[BUFFER_SIZE-1] : cell_data[(k + BUFFER_SIZE - 1) % BUFFER_SIZE];
    assign nxt = (k == BUFFER_SIZE - 1) ? ring_byte : cell_data[(k + 1) % BUFFER_SIZE];

    led_cell #(
      .BUFFER_SIZE (BUFFER_SIZE),
      .IDX         (k)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (op),
      .thr_i  (thr),
      .prv_i  (prv),
      .nxt_i  (nxt),
      .data_o (cell_data[k])
    );
  end

endmodule

// ----- hw/rtl/led_chk.sv -----
// Port-level checker for the line edit buffer, bound to the top level.
// Depends on led_pkg and line_edit_buffer.
module led_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [led_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One item at a time: no acceptance right after an acceptance
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while previous one in work");

  // Cursor never passes the end of the line
  a_cursor_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[17:10] <= m_axis_tdata[25:18])
    else $error("cursor beyond line length");

  // A handled command returns no character, a passed one never reports full
  a_pass_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] || m_axis_tdata[8:1] == 8'd0) &&
                      !(m_axis_tdata[0] && m_axis_tdata[9]))
    else $error("inconsistent pass-back fields");

  // Byte under cursor is zero at end of line
  a_eol_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[17:10] == m_axis_tdata[25:18] |->
      m_axis_tdata[33:26] == 8'd0)
    else $error("nonzero byte at end of line");

endmodule

bind line_edit_buffer led_chk u_led_chk (.*);
